### design/chpw_pkg.sv
// Package for the crosshair overlay pixel writer.
// Holds field widths, item kinds, register indexes, slot colours and the RGB565 packer.
// No dependencies; every other design file refers to it by scoped names.
package chpw_pkg;

  localparam int SLOT_COUNT = 8;
  localparam int COLOUR_DEPTH = 8;
  localparam int POS_W = 16;
  localparam int SIZE_W = 13;
  localparam int PITCH_W = 16;
  localparam int OFFSET_W = 28;
  localparam int DATA_W = 32;
  localparam int MUL_W = 16;
  localparam int PROD_W = 2 * MUL_W;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_INDEX_W = 2;

  typedef logic [1:0] kind_t;
  localparam kind_t KIND_SET   = 2'd0;
  localparam kind_t KIND_CLEAR = 2'd1;
  localparam kind_t KIND_DRAW  = 2'd2;

  typedef logic [CFG_INDEX_W-1:0] cfg_index_t;
  localparam cfg_index_t REG_SCREEN_WIDTH  = 2'd0;
  localparam cfg_index_t REG_SCREEN_HEIGHT = 2'd1;
  localparam cfg_index_t REG_LINE_PITCH    = 2'd2;
  localparam cfg_index_t REG_PIXEL_FORMAT  = 2'd3;

  localparam logic [SIZE_W-1:0]  RESET_WIDTH  = 13'd320;
  localparam logic [SIZE_W-1:0]  RESET_HEIGHT = 13'd240;
  localparam logic [PITCH_W-1:0] RESET_PITCH  = 16'd1280;

  localparam logic FMT_RGB565   = 1'b0;
  localparam logic FMT_XRGB8888 = 1'b1;

  typedef logic [DATA_W-1:0] colour_t;

  localparam colour_t SLOT_COLOUR [COLOUR_DEPTH] = '{
    32'h0000_00FF, 32'h00FF_0000, 32'h0000_FF00, 32'h00FF_FFFF,
    32'h00FF_00FF, 32'h00FF_FF00, 32'h0000_FFFF, 32'h0000_0001
  };

  // Keeps the top five bits of red and blue and the top six of green.
  function automatic colour_t pack565(input colour_t c);
    colour_t packed_c;
    packed_c = {16'h0000, c[23:19], c[15:10], c[7:3]};
    return packed_c;
  endfunction

endpackage

### design/chpw_cmd_if.sv
// Command channel of the crosshair overlay pixel writer: valid/ready plus one item.
// Depends on chpw_pkg for field widths.
interface chpw_cmd_if;
  logic                              valid;
  logic                              ready;
  logic [1:0]                        kind;
  logic [3:0]                        slot;
  logic signed [chpw_pkg::POS_W-1:0] pos_x;
  logic signed [chpw_pkg::POS_W-1:0] pos_y;

  modport source (output valid, kind, slot, pos_x, pos_y, input ready);
  modport sink   (input valid, kind, slot, pos_x, pos_y, output ready);
endinterface

### design/chpw_pix_if.sv
// Pixel write channel of the crosshair overlay pixel writer: valid/ready plus one write.
// Depends on chpw_pkg for field widths.
interface chpw_pix_if;
  logic                            valid;
  logic                            ready;
  logic [chpw_pkg::OFFSET_W-1:0]   write_offset;
  logic [chpw_pkg::DATA_W-1:0]     pixel_data;
  logic                            last_write;

  modport source (output valid, write_offset, pixel_data, last_write, input ready);
  modport sink   (input valid, write_offset, pixel_data, last_write, output ready);
endinterface

### design/chpw_mult.sv
// Shared registered multiplier of the crosshair overlay pixel writer.
// Depends on chpw_pkg for operand widths.
module chpw_mult (
  input  logic                          clk,
  input  logic                          en,
  input  logic [chpw_pkg::MUL_W-1:0]    a,
  input  logic [chpw_pkg::MUL_W-1:0]    b,
  output logic [chpw_pkg::PROD_W-1:0]   prod
);

  always_ff @(posedge clk) begin
    if (en) begin
      prod <= {{chpw_pkg::MUL_W{1'b0}}, a} * {{chpw_pkg::MUL_W{1'b0}}, b};
    end
  end

endmodule

### design/crosshair_overlay_pixel_writer.sv
// Crosshair overlay pixel writer, top level. Depends on chpw_pkg, chpw_cmd_if, chpw_pix_if, chpw_mult.
// Set and clear items keep the sequencer idle, so the command port stays ready.
// Per active slot a draw walks 4 multiply/clamp steps on one shared multiplier, then 5 pixel
// steps; the pixel steps are held for as long as the pixel port stalls.
// Reset (synchronous, rst high) clears all active marks, empties the output register and
// loads 320 x 240, pitch 1280, RGB565.
module crosshair_overlay_pixel_writer #(
  parameter int SLOT_COUNT = chpw_pkg::SLOT_COUNT
) (
  input  logic                                clk,
  input  logic                                rst,
  chpw_cmd_if.sink                            cmd,
  chpw_pix_if.source                          pix,
  input  logic                                cfg_we,
  input  logic [chpw_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [chpw_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int SLOT_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int SIZE_W = chpw_pkg::SIZE_W;
  localparam int OFF_W  = chpw_pkg::OFFSET_W;

  // Sequencer codes. A draw walks MULX -> MULY -> CLPY -> MULROW -> EMIT once per active slot.
  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_MULX   = 3'd1;
  localparam logic [2:0] ST_MULY   = 3'd2;
  localparam logic [2:0] ST_CLPY   = 3'd3;
  localparam logic [2:0] ST_MULROW = 3'd4;
  localparam logic [2:0] ST_EMIT   = 3'd5;

  // Pixel order within one crosshair.
  localparam logic [2:0] PH_CENTRE = 3'd0;
  localparam logic [2:0] PH_LEFT   = 3'd1;
  localparam logic [2:0] PH_RIGHT  = 3'd2;
  localparam logic [2:0] PH_UP     = 3'd3;
  localparam logic [2:0] PH_DOWN   = 3'd4;

  // Configuration registers.
  logic [SIZE_W-1:0]            screen_width;
  logic [SIZE_W-1:0]            screen_height;
  logic [chpw_pkg::PITCH_W-1:0] line_pitch;
  logic                         pixel_format;

  // Slot table. Positions are only read for active slots, so they need no reset.
  logic [chpw_pkg::POS_W-1:0] slot_pos_x [SLOT_COUNT];
  logic [chpw_pkg::POS_W-1:0] slot_pos_y [SLOT_COUNT];
  logic [SLOT_COUNT-1:0]      slot_active;

  // Sequencer state.
  logic [2:0]            state;
  logic [2:0]            phase;
  logic [SLOT_W-1:0]     cur;
  logic [SLOT_COUNT-1:0] rest;
  logic [SIZE_W-1:0]     sx;
  logic [SIZE_W-1:0]     sy;

  // Output register.
  logic                  out_valid;
  logic [OFF_W-1:0]      out_offset;
  logic [chpw_pkg::DATA_W-1:0] out_data;
  logic                  out_last;

  // Shared multiplier.
  logic                         mul_en;
  logic [chpw_pkg::MUL_W-1:0]   mul_a;
  logic [chpw_pkg::MUL_W-1:0]   mul_b;
  logic [chpw_pkg::PROD_W-1:0]  prod;

  chpw_mult u_mult (
    .clk  (clk),
    .en   (mul_en),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  logic cmd_fire;
  logic out_free;
  assign cmd.ready = (state == ST_IDLE);
  assign cmd_fire  = cmd.valid && cmd.ready;
  assign out_free  = !out_valid || pix.ready;

  assign pix.valid        = out_valid;
  assign pix.write_offset = out_offset;
  assign pix.pixel_data   = out_data;
  assign pix.last_write   = out_last;

  // Lowest pending slot: from the active marks when a draw starts, else from the leftovers.
  logic [SLOT_COUNT-1:0] pick_src;
  logic [SLOT_W-1:0]     pick;
  logic [SLOT_COUNT-1:0] pick_mask;
  always_comb begin
    pick_src = (state == ST_IDLE) ? slot_active : rest;
    pick = '0;
    for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
      if (pick_src[i]) begin
        pick = SLOT_W'(i);
      end
    end
    pick_mask = pick_src & ~(SLOT_COUNT'(1) << pick);
  end

  // Positions are mapped to 0..size-1 by (pos + 32768) * size / 65536 with a clamp.
  logic [chpw_pkg::POS_W-1:0] bias_x;
  logic [chpw_pkg::POS_W-1:0] bias_y;
  logic [SIZE_W-1:0]          scaled;
  assign bias_x = slot_pos_x[cur] ^ {1'b1, {(chpw_pkg::POS_W-1){1'b0}}};
  assign bias_y = slot_pos_y[cur] ^ {1'b1, {(chpw_pkg::POS_W-1){1'b0}}};
  assign scaled = prod[chpw_pkg::MUL_W +: SIZE_W];

  always_comb begin
    mul_en = 1'b0;
    mul_a  = '0;
    mul_b  = '0;
    unique case (state)
      ST_MULX: begin
        mul_en = 1'b1;
        mul_a  = bias_x;
        mul_b  = {3'b000, screen_width};
      end
      ST_MULY: begin
        mul_en = 1'b1;
        mul_a  = bias_y;
        mul_b  = {3'b000, screen_height};
      end
      ST_MULROW: begin
        mul_en = 1'b1;
        mul_a  = {3'b000, sy};
        mul_b  = line_pitch;
      end
      default: begin
        mul_en = 1'b0;
      end
    endcase
  end

  // Which of the five pixels fall on the screen; the centre always does.
  logic [4:0] en;
  assign en[PH_CENTRE] = 1'b1;
  assign en[PH_LEFT]   = (sx != '0);
  assign en[PH_RIGHT]  = ({1'b0, sx} + 14'd1) < {1'b0, screen_width};
  assign en[PH_UP]     = (sy != '0);
  assign en[PH_DOWN]   = ({1'b0, sy} + 14'd1) < {1'b0, screen_height};

  // During EMIT the product register holds the row start sy * pitch.
  logic [OFF_W-1:0]   row;
  logic [OFF_W-1:0]   pitch_ext;
  logic [OFF_W-1:0]   row_sel;
  logic [SIZE_W-1:0]  x_sel;
  logic [OFF_W-1:0]   x_bytes;
  logic [OFF_W-1:0]   offset_next;
  logic [chpw_pkg::DATA_W-1:0] colour;
  logic [chpw_pkg::DATA_W-1:0] data_next;
  logic               last_next;
  logic               emit_step;
  logic               emit_load;

  assign row       = prod[OFF_W-1:0];
  assign pitch_ext = {{(OFF_W - chpw_pkg::PITCH_W){1'b0}}, line_pitch};

  always_comb begin
    row_sel = row;
    x_sel   = sx;
    unique case (phase)
      PH_CENTRE: begin
        row_sel = row;
        x_sel   = sx;
      end
      PH_LEFT: begin
        x_sel = sx - 13'd1;
      end
      PH_RIGHT: begin
        x_sel = sx + 13'd1;
      end
      PH_UP: begin
        row_sel = row - pitch_ext;
      end
      PH_DOWN: begin
        row_sel = row + pitch_ext;
      end
      default: begin
        row_sel = row;
      end
    endcase
    if (pixel_format == chpw_pkg::FMT_XRGB8888) begin
      x_bytes = OFF_W'({x_sel, 2'b00});
    end else begin
      x_bytes = OFF_W'({x_sel, 1'b0});
    end
    offset_next = row_sel + x_bytes;
  end

  assign colour    = chpw_pkg::SLOT_COLOUR[3'(cur)];
  assign data_next = (pixel_format == chpw_pkg::FMT_XRGB8888) ? colour
                                                              : chpw_pkg::pack565(colour);
  // Last write of the draw: no slot left and no later pixel of this crosshair on screen.
  assign last_next = (rest == '0) && ((en >> phase) == 5'b00001);
  assign emit_step = (state == ST_EMIT) && (!en[phase] || out_free);
  assign emit_load = (state == ST_EMIT) && en[phase] && out_free;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width  <= chpw_pkg::RESET_WIDTH;
      screen_height <= chpw_pkg::RESET_HEIGHT;
      line_pitch    <= chpw_pkg::RESET_PITCH;
      pixel_format  <= chpw_pkg::FMT_RGB565;
    end else if (cfg_we) begin
      unique case (cfg_index)
        chpw_pkg::REG_SCREEN_WIDTH:  screen_width  <= cfg_data[SIZE_W-1:0];
        chpw_pkg::REG_SCREEN_HEIGHT: screen_height <= cfg_data[SIZE_W-1:0];
        chpw_pkg::REG_LINE_PITCH:    line_pitch    <= cfg_data;
        chpw_pkg::REG_PIXEL_FORMAT:  pixel_format  <= cfg_data[0];
      endcase
    end
  end

  // Slot table writes for set and clear items; out-of-range slots are dropped.
  logic slot_ok;
  assign slot_ok = ({28'd0, cmd.slot} < 32'(SLOT_COUNT));

  always_ff @(posedge clk) begin
    if (cmd_fire && slot_ok && (cmd.kind == chpw_pkg::KIND_SET)) begin
      slot_pos_x[cmd.slot[SLOT_W-1:0]] <= cmd.pos_x;
      slot_pos_y[cmd.slot[SLOT_W-1:0]] <= cmd.pos_y;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_active <= '0;
    end else if (cmd_fire && slot_ok) begin
      case (cmd.kind)
        chpw_pkg::KIND_SET:   slot_active[cmd.slot[SLOT_W-1:0]] <= 1'b1;
        chpw_pkg::KIND_CLEAR: slot_active[cmd.slot[SLOT_W-1:0]] <= 1'b0;
        default: ;
      endcase
    end
  end

  // Sequencer.
  logic draw_go;
  assign draw_go = cmd_fire && (cmd.kind == chpw_pkg::KIND_DRAW) &&
                   (screen_width != '0) && (screen_height != '0) && (slot_active != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      phase <= PH_CENTRE;
      rest  <= '0;
      cur   <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (draw_go) begin
            cur   <= pick;
            rest  <= pick_mask;
            state <= ST_MULX;
          end
        end
        ST_MULX: begin
          state <= ST_MULY;
        end
        ST_MULY: begin
          state <= ST_CLPY;
        end
        ST_CLPY: begin
          state <= ST_MULROW;
        end
        ST_MULROW: begin
          phase <= PH_CENTRE;
          state <= ST_EMIT;
        end
        ST_EMIT: begin
          if (emit_step) begin
            if (phase == PH_DOWN) begin
              phase <= PH_CENTRE;
              if (rest != '0) begin
                cur   <= pick;
                rest  <= pick_mask;
                state <= ST_MULX;
              end else begin
                state <= ST_IDLE;
              end
            end else begin
              phase <= phase + 3'd1;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Scaled coordinates, clamped to the last pixel or line.
  always_ff @(posedge clk) begin
    if (state == ST_MULY) begin
      sx <= (scaled >= screen_width) ? screen_width - 13'd1 : scaled;
    end
    if (state == ST_CLPY) begin
      sy <= (scaled >= screen_height) ? screen_height - 13'd1 : scaled;
    end
  end

  // Output register: loads a write whenever it is empty or its beat is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_load) begin
      out_valid <= 1'b1;
    end else if (pix.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_load) begin
      out_offset <= offset_next;
      out_data   <= data_next;
      out_last   <= last_next;
    end
  end

endmodule

### bench/crosshair_write_checker.sv
// Scoreboard for the crosshair overlay pixel writer bench.
// Watches the command, pixel and register ports, predicts every pixel write and compares.
// Depends on chpw_pkg and the chpw_cmd_if / chpw_pix_if interfaces.
module crosshair_write_checker (
  input  logic                             clk,
  input  logic                             rst,
  chpw_cmd_if                              cmd,
  chpw_pix_if                              pix,
  input  logic                             cfg_we,
  input  logic [chpw_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [chpw_pkg::CFG_DATA_W-1:0]  cfg_data,
  output int                               mismatches,
  output int                               writes_pending
);
  import chpw_pkg::*;

  typedef struct packed {
    logic [OFFSET_W-1:0] offset;
    logic [DATA_W-1:0]   data;
    logic                is_last;
  } pixel_write_t;

  localparam logic [31:0] CURSOR_RGB [8] = '{
    32'h0000_00FF, 32'h00FF_0000, 32'h0000_FF00, 32'h00FF_FFFF,
    32'h00FF_00FF, 32'h00FF_FF00, 32'h0000_FFFF, 32'h0000_0001
  };

  logic [SIZE_W-1:0]  width_q;
  logic [SIZE_W-1:0]  height_q;
  logic [PITCH_W-1:0] pitch_q;
  logic               xrgb_q;
  logic [POS_W-1:0]   cursor_x [SLOT_COUNT];
  logic [POS_W-1:0]   cursor_y [SLOT_COUNT];
  logic               cursor_on [SLOT_COUNT];
  pixel_write_t       pending_pixels [$];

  // Maps a signed position so that the full 16-bit range spans 0..size-1.
  function automatic logic [31:0] to_screen(input logic [POS_W-1:0] raw,
                                            input logic [SIZE_W-1:0] size);
    logic [31:0] biased;
    logic [31:0] v;
    biased = {16'h0000, ~raw[15], raw[14:0]};
    v = (biased * size) >> 16;
    if (v >= size) v = size - 1;
    return v;
  endfunction

  function automatic logic [31:0] to_rgb565(input logic [31:0] c);
    logic [31:0] r5, g6, b5;
    r5 = (c >> 19) & 32'h1F;
    g6 = (c >> 10) & 32'h3F;
    b5 = (c >> 3) & 32'h1F;
    return (r5 << 11) | (g6 << 5) | b5;
  endfunction

  task automatic queue_pixel(input logic [31:0] x, input logic [31:0] y,
                             input logic [31:0] colour);
    logic [63:0]  off;
    pixel_write_t w;
    off = 64'(y) * 64'(pitch_q) + 64'(x) * (xrgb_q ? 64'd4 : 64'd2);
    w.offset  = off[OFFSET_W-1:0];
    w.data    = xrgb_q ? colour : to_rgb565(colour);
    w.is_last = 1'b0;
    pending_pixels.push_back(w);
  endtask

  // Walks the active cursors in slot order: center, left, right, up, down.
  task automatic plot_crosshairs();
    int           base;
    logic [31:0]  x, y;
    pixel_write_t tail;
    base = pending_pixels.size();
    if (width_q == 0 || height_q == 0) return;
    for (int s = 0; s < SLOT_COUNT; s++) begin
      if (cursor_on[s]) begin
        x = to_screen(cursor_x[s], width_q);
        y = to_screen(cursor_y[s], height_q);
        queue_pixel(x, y, CURSOR_RGB[s]);
        if (x >= 1) queue_pixel(x - 1, y, CURSOR_RGB[s]);
        if (x + 1 < width_q) queue_pixel(x + 1, y, CURSOR_RGB[s]);
        if (y >= 1) queue_pixel(x, y - 1, CURSOR_RGB[s]);
        if (y + 1 < height_q) queue_pixel(x, y + 1, CURSOR_RGB[s]);
      end
    end
    if (pending_pixels.size() > base) begin
      tail = pending_pixels.pop_back();
      tail.is_last = 1'b1;
      pending_pixels.push_back(tail);
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    pixel_write_t want;
    if (rst) begin
      width_q  = RESET_WIDTH;
      height_q = RESET_HEIGHT;
      pitch_q  = RESET_PITCH;
      xrgb_q   = FMT_RGB565;
      for (int s = 0; s < SLOT_COUNT; s++) begin
        cursor_x[s]  = '0;
        cursor_y[s]  = '0;
        cursor_on[s] = 1'b0;
      end
      pending_pixels.delete();
      mismatches = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_SCREEN_WIDTH:  width_q  = cfg_data[SIZE_W-1:0];
          REG_SCREEN_HEIGHT: height_q = cfg_data[SIZE_W-1:0];
          REG_LINE_PITCH:    pitch_q  = cfg_data[PITCH_W-1:0];
          REG_PIXEL_FORMAT:  xrgb_q   = cfg_data[0];
          default: ;
        endcase
      end
      if (cmd.valid && cmd.ready) begin
        case (cmd.kind)
          KIND_SET: begin
            if (cmd.slot < SLOT_COUNT) begin
              cursor_x[cmd.slot]  = cmd.pos_x;
              cursor_y[cmd.slot]  = cmd.pos_y;
              cursor_on[cmd.slot] = 1'b1;
            end
          end
          KIND_CLEAR: begin
            if (cmd.slot < SLOT_COUNT) begin
              cursor_x[cmd.slot]  = '0;
              cursor_y[cmd.slot]  = '0;
              cursor_on[cmd.slot] = 1'b0;
            end
          end
          KIND_DRAW: plot_crosshairs();
          default: ;
        endcase
      end
      if (pix.valid && pix.ready) begin
        if (pending_pixels.size() == 0) begin
          $error("unexpected pixel write: write_offset 0x%0h pixel_data 0x%0h last_write %0b",
                 pix.write_offset, pix.pixel_data, pix.last_write);
          mismatches++;
        end else begin
          want = pending_pixels.pop_front();
          check_field("write_offset", 32'(want.offset), 32'(pix.write_offset));
          check_field("pixel_data", want.data, pix.pixel_data);
          check_field("last_write", 32'(want.is_last), 32'(pix.last_write));
        end
      end
    end
    writes_pending = pending_pixels.size();
  end

endmodule

### bench/tb_top.sv
// Bench top for the crosshair overlay pixel writer.
// Makes commands, register writes and pixel-port backpressure; crosshair_write_checker judges.
// Depends on chpw_pkg, chpw_cmd_if, chpw_pix_if, the block and the checker.
module tb_top;
  import chpw_pkg::*;

  // Kind 3 has no meaning in the block; it must be swallowed without any write.
  localparam kind_t KIND_UNUSED = 2'd3;

  // The drain wait covers any draw that produces no beat at all. The cycle limit
  // assumes every draw at 40 beats, every beat behind a long receiver stall, and
  // still leaves a wide margin.
  localparam int DRAIN_CYCLES = 100;
  localparam int CYCLE_LIMIT  = 600000;

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  cfg_index_t            cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  int                    mismatches;
  int                    writes_pending;
  int                    cycles = 0;
  int                    items_sent = 0;
  // Idle percentages; the first pattern has the receiver stalling more often.
  int                    send_idle_pct = 12;
  int                    recv_stall_pct = 55;

  chpw_cmd_if cmd();
  chpw_pix_if pix();

  crosshair_overlay_pixel_writer u_dut (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .pix       (pix),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  crosshair_write_checker u_checker (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .pix            (pix),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .mismatches     (mismatches),
    .writes_pending (writes_pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Receiver backpressure: ready is redrawn every cycle from the current stall rate.
  always @(posedge clk) begin
    pix.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Watchdog. A hung handshake ends the run here as a failure.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Offers one command beat and returns at the edge where it is taken. Valid is
  // left high so that a following call can present its beat back to back; the
  // ready check happens at the falling edge, where every signal is settled.
  task automatic send_item(input kind_t kind, input logic [3:0] slot,
                           input logic [15:0] x, input logic [15:0] y);
    while ($urandom_range(99) < send_idle_pct) begin
      cmd.valid <= 1'b0;
      @(posedge clk);
    end
    cmd.valid <= 1'b1;
    cmd.kind  <= kind;
    cmd.slot  <= slot;
    cmd.pos_x <= x;
    cmd.pos_y <= y;
    do @(negedge clk); while (!cmd.ready);
    @(posedge clk);
    items_sent++;
    // Switch idle patterns as the run goes on: receiver-heavy stalls first,
    // then sender-heavy gaps, then full throughput on both sides.
    if (items_sent == 140) begin
      send_idle_pct  = 55;
      recv_stall_pct = 12;
    end else if (items_sent == 280) begin
      send_idle_pct  = 0;
      recv_stall_pct = 0;
    end
  endtask

  // Holds the sender back until every predicted pixel has come out, then lets
  // the block finish any draw that produces no beats.
  task automatic wait_idle();
    cmd.valid <= 1'b0;
    do @(negedge clk); while (writes_pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
  endtask

  // Reprograms the whole screen description while the block is quiet.
  task automatic load_screen(input int w, input int h, input int pitch, input logic fmt);
    wait_idle();
    write_reg(REG_SCREEN_WIDTH, CFG_DATA_W'(w));
    write_reg(REG_SCREEN_HEIGHT, CFG_DATA_W'(h));
    write_reg(REG_LINE_PITCH, CFG_DATA_W'(pitch));
    write_reg(REG_PIXEL_FORMAT, {{(CFG_DATA_W-1){1'b0}}, fmt});
    cfg_we <= 1'b0;
  endtask

  // Positions lean toward the range ends and zero, where the scaling clamps
  // and the crosshair arms fall off the screen edges.
  function automatic logic [15:0] random_pos();
    case ($urandom_range(7))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      3: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  // Sends 'count' random commands.
  // Sets dominate so that most slots stay active and draws produce many beats;
  // roughly one command in seven is noise the block must ignore.
  task automatic run_random(input int count);
    int          done;
    int          pick;
    kind_t       kind;
    logic [3:0]  slot;
    done = 0;
    while (done < count) begin
      pick  = $urandom_range(99);
      slot  = 4'($urandom_range(SLOT_COUNT - 1));
      if (pick < 42) begin
        kind = KIND_SET;
      end else if (pick < 56) begin
        kind = KIND_CLEAR;
      end else if (pick < 86) begin
        kind = KIND_DRAW;
        slot = 4'($urandom);
      end else if (pick < 95) begin
        kind  = $urandom_range(1) ? KIND_SET : KIND_CLEAR;
        slot  = 4'($urandom_range(15, SLOT_COUNT));
      end else begin
        kind  = KIND_UNUSED;
        slot  = 4'($urandom);
      end
      send_item(kind, slot, random_pos(), random_pos());
      done++;
    end
  endtask

  initial begin
    rst       <= 1'b1;
    cmd.valid <= 1'b0;
    cmd.kind  <= KIND_SET;
    cmd.slot  <= '0;
    cmd.pos_x <= '0;
    cmd.pos_y <= '0;
    cfg_we    <= 1'b0;
    cfg_index <= REG_SCREEN_WIDTH;
    cfg_data  <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed part on the reset screen of 320 x 240, pitch 1280, RGB565.
    // A draw with nothing active must stay silent.
    send_item(KIND_DRAW, 4'd0, 16'h0000, 16'h0000);
    // Corners and center: the top-left cursor loses its left and up arms,
    // the bottom-right one its right and down arms.
    send_item(KIND_SET, 4'd0, 16'h8000, 16'h8000);
    send_item(KIND_SET, 4'd1, 16'h7FFF, 16'h7FFF);
    send_item(KIND_SET, 4'd2, 16'h0000, 16'h0000);
    send_item(KIND_SET, 4'd7, 16'hFFFF, 16'h0001);
    // Slots past the table and the unused kind are all dropped.
    send_item(KIND_SET, 4'd8, 16'h1234, 16'h4321);
    send_item(KIND_SET, 4'd15, 16'h7FFF, 16'h8000);
    send_item(KIND_CLEAR, 4'd12, 16'h0000, 16'h0000);
    send_item(KIND_UNUSED, 4'd3, 16'h5555, 16'hAAAA);
    send_item(KIND_DRAW, 4'd0, 16'h0000, 16'h0000);
    // Clearing a slot takes its crosshair out of the next draw.
    send_item(KIND_CLEAR, 4'd1, 16'h0000, 16'h0000);
    send_item(KIND_DRAW, 4'd15, 16'hFFFF, 16'hFFFF);
    // Fill every slot so that one draw covers all eight crosshairs.
    send_item(KIND_SET, 4'd3, 16'h5555, 16'hAAAA);
    send_item(KIND_SET, 4'd4, 16'hAAAA, 16'h5555);
    send_item(KIND_SET, 4'd5, 16'h7FFF, 16'h8000);
    send_item(KIND_SET, 4'd6, 16'h8000, 16'h7FFF);
    send_item(KIND_SET, 4'd1, 16'h4000, 16'hC000);
    send_item(KIND_DRAW, 4'd0, 16'h0000, 16'h0000);

    // Random phases, each on its own screen setup. The reset setup goes first.
    run_random(60);
    // Zero width: draws produce nothing.
    load_screen(0, 240, 1280, FMT_RGB565);
    run_random(15);
    // One-pixel screen with zero pitch: only the center pixel survives.
    load_screen(1, 1, 0, FMT_XRGB8888);
    run_random(45);
    // A 4096 x 4096 screen and the largest pitch.
    load_screen(4096, 4096, 65535, FMT_XRGB8888);
    run_random(60);
    // Zero height.
    load_screen(4096, 0, 65535, FMT_RGB565);
    run_random(15);
    // Tiny screen where every crosshair loses its left or right arm off an edge.
    load_screen(2, 3, 7, FMT_RGB565);
    run_random(45);
    load_screen(640, 480, 2560, FMT_XRGB8888);
    run_random(60);
    load_screen($urandom_range(64, 1), $urandom_range(64, 1), $urandom_range(65535),
                1'($urandom_range(1)));
    run_random(60);
    load_screen(320, 240, 1280, FMT_RGB565);
    run_random(40);

    // Let everything drain, then give the verdict.
    wait_idle();
    if (mismatches == 0 && writes_pending == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
